// ===== rtl/rational_arithmetic_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau check failed");

// next-cycle implication, checked outside reset
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau check failed");

`endif

// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam int OP_W    = 4;
  localparam int NUM_FW  = 16;
  localparam int DEN_FW  = 15;
  localparam int RNUM_FW = 32;
  localparam int RDEN_FW = 30;

  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_EQ  = 4'd4;
  localparam logic [OP_W-1:0] OP_NE  = 4'd5;
  localparam logic [OP_W-1:0] OP_LT  = 4'd6;
  localparam logic [OP_W-1:0] OP_GT  = 4'd7;
  localparam logic [OP_W-1:0] OP_LE  = 4'd8;
  localparam logic [OP_W-1:0] OP_GE  = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [NUM_FW-1:0] a_num;
    logic [DEN_FW-1:0]        a_den;
    logic signed [NUM_FW-1:0] b_num;
    logic [DEN_FW-1:0]        b_den;
  } in_req_t;

  typedef struct packed {
    logic signed [RNUM_FW-1:0] result_num;
    logic [RDEN_FW-1:0]        result_den;
    logic                      relation_true;
    logic                      status;
  } out_rsp_t;

endpackage

// ===== rtl/rau_queue.sv =====
// ----------------------------------------------------------------------------
// rau_queue
// Small FIFO between the front end and the reduction engine.
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_r];

  always_comb begin
    wr_nxt  = do_push ? AW'(wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? AW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/rau_front.sv =====
// ----------------------------------------------------------------------------
// rau_front
// Operand decode, cross products and request classification.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; #(
  parameter int W = OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_req_t           in_data,
  output logic              q_push,
  output logic [4*W+3:0]    q_data,
  input  logic              q_full
);

  localparam int MW = 2 * W;
  localparam int ZW = 64;

  // decode
  logic [ZW-1:0]       anz, adz, bnz, bdz;
  logic signed [W-1:0] dec_an, dec_bn;
  logic [W-2:0]        dec_ad, dec_bd;

  assign anz    = ZW'(unsigned'(in_data.a_num));
  assign bnz    = ZW'(unsigned'(in_data.b_num));
  assign adz    = ZW'(in_data.a_den);
  assign bdz    = ZW'(in_data.b_den);
  assign dec_an = signed'(anz[W-1:0]);
  assign dec_bn = signed'(bnz[W-1:0]);
  assign dec_ad = (adz[W-2:0] == '0) ? (W-1)'(1) : adz[W-2:0];
  assign dec_bd = (bdz[W-2:0] == '0) ? (W-1)'(1) : bdz[W-2:0];

  // stage 1: decoded operands
  logic                s1_v_r;
  logic [OP_W-1:0]     op1_r;
  logic signed [W-1:0] an1_r, bn1_r;
  logic [W-2:0]        ad1_r, bd1_r;

  // stage 2: products
  logic                 s2_v_r;
  logic [OP_W-1:0]      op2_r;
  logic signed [MW-1:0] lhs2_r, rhs2_r, nn2_r, dn2_r;
  logic [MW-1:0]        dd2_r;
  logic signed [W-1:0]  an2_r;
  logic [W-2:0]         ad2_r;
  logic                 eq2_r, bz2_r;

  logic s2_free, s1_adv;

  assign q_push   = s2_v_r;
  assign s2_free  = !s2_v_r || !q_full;
  assign s1_adv   = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;

  logic signed [W-1:0]  sad, sbd;
  logic signed [MW-1:0] lhs_c, rhs_c, nn_c, dn_c;
  logic [MW-1:0]        dd_c;

  assign sad   = signed'({1'b0, ad1_r});
  assign sbd   = signed'({1'b0, bd1_r});
  assign lhs_c = an1_r * sbd;
  assign rhs_c = bn1_r * sad;
  assign nn_c  = an1_r * bn1_r;
  assign dn_c  = sad * bn1_r;
  assign dd_c  = MW'(ad1_r) * MW'(bd1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op1_r <= in_data.operation;
      an1_r <= dec_an;
      ad1_r <= dec_ad;
      bn1_r <= dec_bn;
      bd1_r <= dec_bd;
    end
    if (s1_adv) begin
      op2_r  <= op1_r;
      lhs2_r <= lhs_c;
      rhs2_r <= rhs_c;
      nn2_r  <= nn_c;
      dn2_r  <= dn_c;
      dd2_r  <= dd_c;
      an2_r  <= an1_r;
      ad2_r  <= ad1_r;
      eq2_r  <= (an1_r == bn1_r) && (ad1_r == bd1_r);
      bz2_r  <= (bn1_r == '0);
    end
  end

  // classify: numerator/denominator to reduce, or a finished result
  logic signed [MW:0] nsel, dsel, nabs, dabs;
  logic               byp, rel, stat, neg;
  logic [MW-1:0]      un, ud;
  logic               lt, gt;

  assign lt = (lhs2_r < rhs2_r);
  assign gt = (rhs2_r < lhs2_r);

  always_comb begin
    nsel = '0;
    dsel = (MW+1)'(1);
    byp  = 1'b1;
    rel  = 1'b0;
    stat = 1'b0;
    case (op2_r)
      OP_ADD: begin
        nsel = (MW+1)'(lhs2_r) + (MW+1)'(rhs2_r);
        dsel = signed'({1'b0, dd2_r});
        byp  = 1'b0;
      end
      OP_SUB: begin
        nsel = (MW+1)'(lhs2_r) - (MW+1)'(rhs2_r);
        dsel = signed'({1'b0, dd2_r});
        byp  = 1'b0;
      end
      OP_MUL: begin
        nsel = (MW+1)'(nn2_r);
        dsel = signed'({1'b0, dd2_r});
        byp  = 1'b0;
      end
      OP_DIV: begin
        if (bz2_r) begin
          // zero divisor: hand back a as decoded
          nsel = (MW+1)'(an2_r);
          dsel = signed'((MW+1)'(ad2_r));
          stat = 1'b1;
        end else begin
          nsel = (MW+1)'(lhs2_r);
          dsel = (MW+1)'(dn2_r);
          byp  = 1'b0;
        end
      end
      OP_EQ:   rel = eq2_r;
      OP_NE:   rel = !eq2_r;
      OP_LT:   rel = lt;
      OP_GT:   rel = gt;
      OP_LE:   rel = !gt;
      OP_GE:   rel = !lt;
      default: rel = 1'b0;
    endcase
  end

  assign nabs   = nsel[MW] ? -nsel : nsel;
  assign dabs   = dsel[MW] ? -dsel : dsel;
  assign un     = nabs[MW-1:0];
  assign ud     = dabs[MW-1:0];
  assign neg    = (nsel[MW] ^ dsel[MW]) && (un != '0);
  assign q_data = {byp, neg, rel, stat, un, ud};

endmodule

// ===== rtl/rau_back.sv =====
// ----------------------------------------------------------------------------
// rau_back
// Binary gcd, restoring division by the gcd, result register.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; #(
  parameter int W = OPERAND_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic [4*W+3:0] q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output out_rsp_t       out_data
);

  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW + 1);
  localparam int CW = $clog2(MW);
  // wide enough for the signed numerator and the result fields at any W
  localparam int XW = (MW + 2 > RNUM_FW) ? MW + 2 : RNUM_FW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GCD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic          e_byp, e_neg, e_rel, e_stat;
  logic [MW-1:0] e_un, e_ud;
  assign {e_byp, e_neg, e_rel, e_stat, e_un, e_ud} = q_data;

  logic [1:0]    st_r, st_nxt;
  logic [MW-1:0] x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [MW-1:0] qn_r, qn_nxt, qd_r, qd_nxt, rmn_r, rmn_nxt, rmd_r, rmd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, rel_r, rel_nxt, stat_r, stat_nxt;
  logic          out_v_r, out_v_nxt;
  out_rsp_t      out_r, out_nxt;

  logic [MW:0]   tn, td, tns, tds;
  logic          gn, gd;
  logic [XW-1:0] nm, sv, dm;

  // one quotient bit per cycle on both dividends
  assign tn  = {rmn_r, qn_r[MW-1]};
  assign td  = {rmd_r, qd_r[MW-1]};
  assign gn  = (tn >= {1'b0, g_r});
  assign gd  = (td >= {1'b0, g_r});
  assign tns = gn ? (tn - {1'b0, g_r}) : tn;
  assign tds = gd ? (td - {1'b0, g_r}) : td;

  assign nm = XW'(qn_r);
  assign dm = XW'(qd_r);
  assign sv = neg_r ? (~nm + XW'(1)) : nm;

  always_comb begin
    st_nxt    = st_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    g_nxt     = g_r;
    qn_nxt    = qn_r;
    qd_nxt    = qd_r;
    rmn_nxt   = rmn_r;
    rmd_nxt   = rmd_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    rel_nxt   = rel_r;
    stat_nxt  = stat_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r && !out_ready;
    q_pop     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          qn_nxt   = e_un;
          qd_nxt   = e_ud;
          x_nxt    = e_un;
          y_nxt    = e_ud;
          k_nxt    = '0;
          neg_nxt  = e_neg;
          rel_nxt  = e_rel;
          stat_nxt = e_stat;
          st_nxt   = e_byp ? ST_FIN : ST_GCD;
        end
      end
      ST_GCD: begin
        if (x_r == '0) begin
          g_nxt   = y_r << k_r;
          rmn_nxt = '0;
          rmd_nxt = '0;
          cnt_nxt = CW'(MW - 1);
          st_nxt  = ST_DIV;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = KW'(k_r + 1'b1);
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r >= y_r) begin
          x_nxt = (x_r - y_r) >> 1;
        end else begin
          y_nxt = (y_r - x_r) >> 1;
        end
      end
      ST_DIV: begin
        rmn_nxt = tns[MW-1:0];
        rmd_nxt = tds[MW-1:0];
        qn_nxt  = {qn_r[MW-2:0], gn};
        qd_nxt  = {qd_r[MW-2:0], gd};
        cnt_nxt = CW'(cnt_r - 1'b1);
        if (cnt_r == '0) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_v_r || out_ready) begin
          out_nxt.result_num    = signed'(sv[RNUM_FW-1:0]);
          out_nxt.result_den    = dm[RDEN_FW-1:0];
          out_nxt.relation_true = rel_r;
          out_nxt.status        = stat_r;
          out_v_nxt             = 1'b1;
          st_nxt                = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    k_r    <= k_nxt;
    g_r    <= g_nxt;
    qn_r   <= qn_nxt;
    qd_r   <= qd_nxt;
    rmn_r  <= rmn_nxt;
    rmd_r  <= rmd_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    rel_r  <= rel_nxt;
    stat_r <= stat_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Path: the front stages (decode, products), the queue, then the back end:
//   arithmetic ops take the binary-gcd steps plus 2*W division steps before
//   the result register; compares and zero-divisor go straight to it.
// The back end takes a new request only once its gcd loop and the
//   one-bit-per-cycle divider are through with the last; the front keeps filling the queue.
// Reset: synchronous active-low rst_n clears valids, queue pointers and state.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add/sub/mul/div with gcd reduction, and six relations.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  // queue entry: {bypass, neg, relation, status, |num|, |den|}
  localparam int EW = 4 * OPERAND_WIDTH + 4;

  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  // front: decode operands, zero denominators read as one, form cross
  // products, finish compares and divide-by-zero right away
  rau_front #(.W(OPERAND_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  // decouples the pipelined front from the long-running reduction
  rau_queue #(.DW(EW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: gcd of magnitudes, divide both by it, put sign on numerator;
  // result register lets the next request start while this one waits
  rau_back #(.W(OPERAND_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the result channel of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"

module rau_checker import rau_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input out_rsp_t out_data
);

  `RAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `RAU_ASSERT_NOW(a_den_nonzero, out_valid, out_data.result_den != '0)
  `RAU_ASSERT_NOW(a_rel_zero_frac, out_valid && out_data.relation_true,
                  out_data.result_num == '0 && out_data.result_den == RDEN_FW'(1))
  `RAU_ASSERT_NOW(a_status_excl, out_valid && out_data.status, !out_data.relation_true)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational arithmetic unit: directed corner
// requests, random fraction streams, random idling and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import rau_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_data;

  // expected responses, oldest first
  out_rsp_t expected_rsps[$];
  int       fail_count;
  // sender / receiver idling controls
  bit       src_idle_en;
  bit       sink_idle_en;
  bit       sink_hold;

  rational_arithmetic_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint abs64(longint x);
    return x < 0 ? -x : x;
  endfunction

  // reduce n/d by the gcd of magnitudes, sign into numerator
  function automatic void reduce_frac(longint n, longint d,
                                      output longint rn, output longint rd);
    longint un, ud, x, y, t;
    bit     neg;
    un  = abs64(n);
    ud  = abs64(d);
    neg = ((n < 0) != (d < 0)) && un != 0;
    x   = un;
    y   = ud;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    un = un / x;
    ud = ud / x;
    rn = neg ? -un : un;
    rd = ud;
  endfunction

  // expected response of one request
  function automatic out_rsp_t rational_result(in_req_t r);
    out_rsp_t o;
    longint   an, ad, bn, bd, lhs, rhs, rn, rd;
    bit       rel, st;
    an  = longint'(r.a_num);
    bn  = longint'(r.b_num);
    ad  = (r.a_den == 0) ? 1 : longint'(r.a_den);
    bd  = (r.b_den == 0) ? 1 : longint'(r.b_den);
    lhs = an * bd;
    rhs = bn * ad;
    rn  = 0;
    rd  = 1;
    rel = 1'b0;
    st  = 1'b0;
    case (r.operation)
      OP_ADD: reduce_frac(lhs + rhs, ad * bd, rn, rd);
      OP_SUB: reduce_frac(lhs - rhs, ad * bd, rn, rd);
      OP_MUL: reduce_frac(an * bn, ad * bd, rn, rd);
      OP_DIV: begin
        if (bn == 0) begin
          // zero divisor: a passes through, flagged
          rn = an;
          rd = ad;
          st = 1'b1;
        end else begin
          reduce_frac(lhs, ad * bn, rn, rd);
        end
      end
      OP_EQ: rel = (an == bn) && (ad == bd);
      OP_NE: rel = !((an == bn) && (ad == bd));
      OP_LT: rel = lhs < rhs;
      OP_GT: rel = rhs < lhs;
      OP_LE: rel = !(rhs < lhs);
      OP_GE: rel = !(lhs < rhs);
      default: ;
    endcase
    o.result_num    = rn[31:0];
    o.result_den    = rd[29:0];
    o.relation_true = rel;
    o.status        = st;
    return o;
  endfunction

  // send one request, with an optional idle burst before it;
  // valid stays up afterwards so the next request can follow directly
  task automatic send_req(in_req_t r);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rsps.push_back(rational_result(r));
  endtask

  // drop valid after the last request of a sequence
  task automatic end_sequence();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_req_t mk_req(logic [3:0] op, int an, int ad, int bn, int bd);
    in_req_t r;
    r.operation = op;
    r.a_num     = an[15:0];
    r.a_den     = ad[14:0];
    r.b_num     = bn[15:0];
    r.b_den     = bd[14:0];
    return r;
  endfunction

  function automatic int gcd_int(int x, int y);
    int t;
    if (x < 0) x = -x;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // random reduced fraction; mostly small magnitudes, sometimes full range
  task automatic rand_frac(output int n, output int d);
    int g;
    if ($urandom_range(0, 3) == 0) begin
      n = int'($urandom_range(0, 65534)) - 32767;
      d = int'($urandom_range(1, 32767));
    end else begin
      n = int'($urandom_range(0, 200)) - 100;
      d = int'($urandom_range(1, 100));
    end
    if ($urandom_range(0, 15) == 0) n = 0;
    g = gcd_int(n, d);
    if (g == 0) g = d;
    n = n / g;
    d = d / g;
  endtask

  task automatic wait_drain();
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // response checker and receiver idling
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response %p", out_data);
        fail_count++;
      end else begin
        e = expected_rsps.pop_front();
        if (out_data.result_num !== e.result_num) begin
          $error("result_num exp %0d got %0d", e.result_num, out_data.result_num);
          fail_count++;
        end
        if (out_data.result_den !== e.result_den) begin
          $error("result_den exp %0d got %0d", e.result_den, out_data.result_den);
          fail_count++;
        end
        if (out_data.relation_true !== e.relation_true) begin
          $error("relation_true exp %0b got %0b", e.relation_true,
                 out_data.relation_true);
          fail_count++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0b got %0b", e.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    logic [3:0] op;
    // extremes and each operation
    send_req(mk_req(OP_ADD, 32767, 1, 32767, 1));
    send_req(mk_req(OP_SUB, -32767, 1, 32767, 1));
    send_req(mk_req(OP_MUL, -32767, 32766, -32767, 32765));
    send_req(mk_req(OP_DIV, 32767, 32767, -1, 32766));
    send_req(mk_req(OP_ADD, 1, 2, -1, 2));        // zero sum -> 0/1
    send_req(mk_req(OP_DIV, 5, 7, 0, 1));         // zero divisor
    send_req(mk_req(OP_DIV, -3, 0, 0, 9));        // zero divisor, zero den
    send_req(mk_req(OP_MUL, 2, 4, 6, 8));         // unreduced inputs
    send_req(mk_req(OP_EQ, 2, 4, 1, 2));          // eq on fields as given
    send_req(mk_req(OP_EQ, 3, 5, 3, 5));
    send_req(mk_req(OP_NE, 3, 5, 3, 5));
    send_req(mk_req(OP_NE, -32768, 0, 0, 0));     // most negative, zero dens
    send_req(mk_req(OP_LT, 1, 3, 1, 2));
    send_req(mk_req(OP_GT, 1, 3, 1, 2));
    send_req(mk_req(OP_LE, 1, 2, 1, 2));
    send_req(mk_req(OP_GE, -1, 2, 1, 2));
    send_req(mk_req(OP_SUB, -32768, 32767, 32767, 1));
    for (int k = 10; k < 16; k++) begin
      op = k[3:0];
      send_req(mk_req(op, 7, 3, 2, 5));           // unknown codes
    end
    end_sequence();
  endtask

  task automatic test_random(int count);
    int          an, ad, bn, bd;
    in_req_t     r;
    logic [95:0] raw;
    for (int k = 0; k < count; k++) begin
      rand_frac(an, ad);
      rand_frac(bn, bd);
      if ($urandom_range(0, 9) == 0) begin
        bn = an;
        bd = ad;
      end
      if ($urandom_range(0, 19) == 0) begin
        // raw noise: every bit pattern, zero dens, unknown codes
        raw = {$urandom, $urandom, $urandom};
        r   = in_req_t'(raw[$bits(in_req_t)-1:0]);
      end else begin
        r = mk_req(4'($urandom_range(0, 9)), an, ad, bn, bd);
      end
      send_req(r);
    end
    end_sequence();
  endtask

  // receiver stalls long so the queue fills and in_ready drops
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (600) @(posedge clk);
        sink_hold = 1'b0;
      end
      test_random(8);
    join
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    fail_count   = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    sink_hold    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_drain();                 // sender pause until all responses are in
    test_backpressure();
    test_random(350);
    src_idle_en  = 1'b0;          // final stretch without idling
    sink_idle_en = 1'b0;
    test_random(70);
    wait_drain();
    repeat (200) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
